### src/format_string_number_printer_assert.svh
// Assertion macros shared by the checker of the format string number printer.
`ifndef FORMAT_STRING_NUMBER_PRINTER_ASSERT_SVH
`define FORMAT_STRING_NUMBER_PRINTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSNP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("format printer port check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FSNP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("format printer port check failed");

`endif

### src/fsnp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsnp_pkg
// Types, codes and character tables of the format string number printer.
// ----------------------------------------------------------------------------
package fsnp_pkg;

    localparam int ARG_BITS_DEF = 32;
    localparam int VALUE_W      = 32;

    // Input operation codes.
    localparam logic [1:0] OP_FMT  = 2'd0;
    localparam logic [1:0] OP_WORD = 2'd1;
    localparam logic [1:0] OP_STR  = 2'd2;
    localparam logic [1:0] OP_NULL = 2'd3;

    // Pending argument kinds.
    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_SDEC = 3'd1;
    localparam logic [2:0] KIND_UDEC = 3'd2;
    localparam logic [2:0] KIND_HEX  = 3'd3;
    localparam logic [2:0] KIND_CHAR = 3'd4;
    localparam logic [2:0] KIND_STR  = 3'd5;

    // Characters.
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_X = 8'h58;
    localparam logic [7:0] CHAR_LOWER_C = 8'h63;
    localparam logic [7:0] CHAR_LOWER_D = 8'h64;
    localparam logic [7:0] CHAR_LOWER_I = 8'h69;
    localparam logic [7:0] CHAR_LOWER_S = 8'h73;
    localparam logic [7:0] CHAR_LOWER_U = 8'h75;
    localparam logic [7:0] CHAR_LOWER_X = 8'h78;

    localparam logic [2:0] NULL_LAST = 3'd5;

    typedef struct packed {
        logic [1:0]         op;
        logic [7:0]         byte_in;
        logic [VALUE_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       message_end;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       push;
        logic       use_digit;
        logic [7:0] char_byte;
        logic       last;
        logic       msg_end;
        logic       load_num;
        logic       num_signed;
        logic       load_hex;
        logic       conv_step;
        logic       shift_digit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic conv_done;
        logic neg;
        logic top_zero;
        logic rem_one;
    } stat_t;

    // One digit of value 0 to 15 as an upper-case character.
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {4'd0, d};
        end
        else begin
            c = CHAR_UPPER_A + {4'd0, d - 4'd10};
        end
        return c;
    endfunction

    // Text printed for a null string argument.
    function automatic logic [7:0] null_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h28;
            3'd1:    c = 8'h6E;
            3'd2:    c = 8'h75;
            3'd3:    c = 8'h6C;
            3'd4:    c = 8'h6C;
            default: c = 8'h29;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

### src/fsnp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsnp_datapath
// Argument register, shift-and-add-3 BCD converter, digit buffer and the
// output register of the result channel.
// ----------------------------------------------------------------------------
module fsnp_datapath #(
    parameter int ARG_BITS = fsnp_pkg::ARG_BITS_DEF
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire [fsnp_pkg::VALUE_W-1:0] value,
    input  fsnp_pkg::cmd_t            cmd,
    output fsnp_pkg::stat_t           stat,
    input  wire                       char_stall,
    output logic                      char_valid,
    output fsnp_pkg::out_t            char_data
);

    localparam int NDIG  = (ARG_BITS * 30103) / 100000 + 1;
    localparam int BCD_W = NDIG * 4;
    localparam int CNT_W = $clog2(ARG_BITS + 1);
    localparam int REM_W = $clog2(NDIG + 1);
    localparam int EXT_W = (ARG_BITS > fsnp_pkg::VALUE_W) ? ARG_BITS : fsnp_pkg::VALUE_W;

    logic [ARG_BITS-1:0] arg_reg, arg_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [CNT_W-1:0]    bitcnt_reg, bitcnt_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic                neg_reg, neg_next;
    logic                valid_reg, valid_next;
    fsnp_pkg::out_t      data_reg, data_next;

    logic [EXT_W-1:0]    v_ext;
    logic [ARG_BITS-1:0] v;
    logic                v_neg;
    logic [BCD_W-1:0]    bcd_adj;
    logic [3:0]          top_digit;

    assign v_ext     = EXT_W'(value);
    assign v         = v_ext[ARG_BITS-1:0];
    assign v_neg     = cmd.num_signed && v[ARG_BITS-1];
    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5) begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    always_comb
    begin
        arg_next    = arg_reg;
        bcd_next    = bcd_reg;
        bitcnt_next = bitcnt_reg;
        rem_next    = rem_reg;
        neg_next    = neg_reg;
        if (cmd.load_num) begin
            arg_next    = v_neg ? (~v) + {{(ARG_BITS-1){1'b0}}, 1'b1} : v;
            neg_next    = v_neg;
            bcd_next    = '0;
            bitcnt_next = CNT_W'(ARG_BITS);
            rem_next    = REM_W'(NDIG);
        end
        else if (cmd.load_hex) begin
            bcd_next = BCD_W'(v);
            neg_next = 1'b0;
            rem_next = REM_W'(NDIG);
        end
        else if (cmd.conv_step) begin
            bcd_next    = {bcd_adj[BCD_W-2:0], arg_reg[ARG_BITS-1]};
            arg_next    = {arg_reg[ARG_BITS-2:0], 1'b0};
            bitcnt_next = bitcnt_reg - CNT_W'(1);
        end
        else if (cmd.shift_digit) begin
            bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
            rem_next = rem_reg - REM_W'(1);
        end
    end

    // The output register frees when its transfer completes.
    always_comb
    begin
        valid_next = valid_reg && char_stall;
        data_next  = data_reg;
        if (cmd.push) begin
            valid_next            = 1'b1;
            data_next.out_byte    = cmd.use_digit ? fsnp_pkg::digit_char(top_digit)
                                                  : cmd.char_byte;
            data_next.run_last    = cmd.last;
            data_next.message_end = cmd.msg_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        arg_reg    <= arg_next;
        bcd_reg    <= bcd_next;
        bitcnt_reg <= bitcnt_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        data_reg   <= data_next;
    end

    assign stat.out_free  = !valid_reg || !char_stall;
    assign stat.conv_done = (bitcnt_reg == '0);
    assign stat.neg       = neg_reg;
    assign stat.top_zero  = (top_digit == 4'd0);
    assign stat.rem_one   = (rem_reg == REM_W'(1));

    assign char_valid = valid_reg;
    assign char_data  = data_reg;

endmodule
`default_nettype wire

### src/fsnp_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsnp_controller
// Parses the format stream, tracks the armed specifier and the pending
// argument kind, and sequences number, sign and null string output.
// ----------------------------------------------------------------------------
module fsnp_controller (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              item_valid,
    output logic             item_stall,
    input  fsnp_pkg::in_t    item,
    input  fsnp_pkg::stat_t  stat,
    output fsnp_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_SKIP,
        ST_DIGITS,
        ST_NULL
    } state_t;

    state_t     state_reg, state_next;
    logic       after_percent_reg, after_percent_next;
    logic [2:0] pending_reg, pending_next;
    logic [2:0] idx_reg, idx_next;
    logic       accept;

    assign item_stall = !((state_reg == ST_IDLE) && stat.out_free);
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        state_next         = state_reg;
        after_percent_next = after_percent_reg;
        pending_next       = pending_reg;
        idx_next           = idx_reg;
        cmd                = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    case (item.op)
                        fsnp_pkg::OP_FMT:
                        begin
                            pending_next = fsnp_pkg::KIND_NONE;
                            if (after_percent_reg) begin
                                after_percent_next = 1'b0;
                                case (item.byte_in)
                                    fsnp_pkg::CHAR_NUL:
                                    begin
                                        cmd.push    = 1'b1;
                                        cmd.last    = 1'b1;
                                        cmd.msg_end = 1'b1;
                                    end
                                    fsnp_pkg::CHAR_LOWER_D,
                                    fsnp_pkg::CHAR_LOWER_I:
                                        pending_next = fsnp_pkg::KIND_SDEC;
                                    fsnp_pkg::CHAR_LOWER_U:
                                        pending_next = fsnp_pkg::KIND_UDEC;
                                    fsnp_pkg::CHAR_LOWER_X,
                                    fsnp_pkg::CHAR_UPPER_X:
                                        pending_next = fsnp_pkg::KIND_HEX;
                                    fsnp_pkg::CHAR_LOWER_C:
                                        pending_next = fsnp_pkg::KIND_CHAR;
                                    fsnp_pkg::CHAR_LOWER_S:
                                        pending_next = fsnp_pkg::KIND_STR;
                                    fsnp_pkg::CHAR_PERCENT:
                                    begin
                                        cmd.push      = 1'b1;
                                        cmd.char_byte = fsnp_pkg::CHAR_PERCENT;
                                        cmd.last      = 1'b1;
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                            else if (item.byte_in == fsnp_pkg::CHAR_NUL) begin
                                cmd.push    = 1'b1;
                                cmd.last    = 1'b1;
                                cmd.msg_end = 1'b1;
                            end
                            else if (item.byte_in == fsnp_pkg::CHAR_PERCENT) begin
                                after_percent_next = 1'b1;
                            end
                            else begin
                                cmd.push      = 1'b1;
                                cmd.char_byte = item.byte_in;
                                cmd.last      = 1'b1;
                            end
                        end
                        fsnp_pkg::OP_WORD:
                        begin
                            case (pending_reg)
                                fsnp_pkg::KIND_SDEC:
                                begin
                                    cmd.load_num   = 1'b1;
                                    cmd.num_signed = 1'b1;
                                    pending_next   = fsnp_pkg::KIND_NONE;
                                    state_next     = ST_CONV;
                                end
                                fsnp_pkg::KIND_UDEC:
                                begin
                                    cmd.load_num = 1'b1;
                                    pending_next = fsnp_pkg::KIND_NONE;
                                    state_next   = ST_CONV;
                                end
                                fsnp_pkg::KIND_HEX:
                                begin
                                    cmd.load_hex = 1'b1;
                                    pending_next = fsnp_pkg::KIND_NONE;
                                    state_next   = ST_SKIP;
                                end
                                fsnp_pkg::KIND_CHAR:
                                begin
                                    cmd.push      = 1'b1;
                                    cmd.char_byte = item.value[7:0];
                                    cmd.last      = 1'b1;
                                    pending_next  = fsnp_pkg::KIND_NONE;
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        fsnp_pkg::OP_STR:
                        begin
                            if (pending_reg == fsnp_pkg::KIND_STR) begin
                                if (item.byte_in == fsnp_pkg::CHAR_NUL) begin
                                    pending_next = fsnp_pkg::KIND_NONE;
                                end
                                else begin
                                    cmd.push      = 1'b1;
                                    cmd.char_byte = item.byte_in;
                                    cmd.last      = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            if (pending_reg == fsnp_pkg::KIND_STR) begin
                                pending_next = fsnp_pkg::KIND_NONE;
                                idx_next     = 3'd0;
                                state_next   = ST_NULL;
                            end
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                if (stat.conv_done) begin
                    state_next = stat.neg ? ST_SIGN : ST_SKIP;
                end
                else begin
                    cmd.conv_step = 1'b1;
                end
            end
            ST_SIGN:
            begin
                if (stat.out_free) begin
                    cmd.push      = 1'b1;
                    cmd.char_byte = fsnp_pkg::CHAR_MINUS;
                    state_next    = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (stat.top_zero && !stat.rem_one) begin
                    cmd.shift_digit = 1'b1;
                end
                else begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (stat.out_free) begin
                    cmd.push        = 1'b1;
                    cmd.use_digit   = 1'b1;
                    cmd.last        = stat.rem_one;
                    cmd.shift_digit = 1'b1;
                    if (stat.rem_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_NULL:
            begin
                if (stat.out_free) begin
                    cmd.push      = 1'b1;
                    cmd.char_byte = fsnp_pkg::null_char(idx_reg);
                    cmd.last      = (idx_reg == fsnp_pkg::NULL_LAST);
                    idx_next      = idx_reg + 3'd1;
                    if (idx_reg == fsnp_pkg::NULL_LAST) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg         <= ST_IDLE;
            after_percent_reg <= 1'b0;
            pending_reg       <= fsnp_pkg::KIND_NONE;
            idx_reg           <= 3'd0;
        end
        else begin
            state_reg         <= state_next;
            after_percent_reg <= after_percent_next;
            pending_reg       <= pending_next;
            idx_reg           <= idx_next;
        end
    end

endmodule
`default_nettype wire

### src/format_string_number_printer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// format_string_number_printer
// Streams a printf-style format string and its arguments and emits the
// formatted characters one per transfer.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A format byte, a string argument byte
// or a %c argument is handled in the idle state and leaves at most one
// character. A %d, %i or %u argument is loaded in its transfer cycle and runs
// through a shift-and-add-3 binary to decimal converter; the block then
// places a minus sign if the value is negative, drops the leading zero
// digits but the last, and places each remaining digit. A %x or %X argument
// skips the converter and takes its hex digits straight from the word, with
// the same leading zero step. A null string argument places the characters
// of "(null)". A stall on the character side holds each step that places a
// character. The output register holds one character, so a new item may be
// taken in the cycle its last character's transfer completes. Each
// character carries run_last on the last character an item causes, and
// message_end on the zero terminator that ends the message, after which no
// specifier is armed and no argument is pending.
module format_string_number_printer #(
    parameter int ARG_BITS = fsnp_pkg::ARG_BITS_DEF
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            item_valid,
    output logic           item_stall,
    input  fsnp_pkg::in_t  item,
    output logic           char_valid,
    input  wire            char_stall,
    output fsnp_pkg::out_t char_data
);

    fsnp_pkg::cmd_t  cmd;
    fsnp_pkg::stat_t stat;

    // Format parsing and output sequencing.
    fsnp_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Number conversion, digit buffer and the output register.
    fsnp_datapath #(
        .ARG_BITS (ARG_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (item.value),
        .cmd        (cmd),
        .stat       (stat),
        .char_stall (char_stall),
        .char_valid (char_valid),
        .char_data  (char_data)
    );

endmodule
`default_nettype wire

### src/fsnp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsnp_checker
// Port-level checks of the format string number printer, bound to the top.
// ----------------------------------------------------------------------------
`include "format_string_number_printer_assert.svh"

module fsnp_checker (
    input wire            clk,
    input wire            rst_n,
    input wire            item_valid,
    input wire            item_stall,
    input fsnp_pkg::in_t  item,
    input wire            char_valid,
    input wire            char_stall,
    input fsnp_pkg::out_t char_data
);

    // A stalled character stays offered.
    `FSNP_ASSERT_NEXT(a_char_hold, clk, rst_n, char_valid && char_stall, char_valid)

    // The message terminator is a zero byte and the last of its item.
    `FSNP_ASSERT_NOW(a_end_is_nul, clk, rst_n, char_valid && char_data.message_end, (char_data.out_byte == fsnp_pkg::CHAR_NUL) && char_data.run_last)

    // A zero format byte always ends the message on the next cycle.
    `FSNP_ASSERT_NEXT(a_nul_ends, clk, rst_n, item_valid && !item_stall && (item.op == fsnp_pkg::OP_FMT) && (item.byte_in == fsnp_pkg::CHAR_NUL), char_valid && char_data.message_end)

endmodule

bind format_string_number_printer fsnp_checker u_fsnp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data)
);
`default_nettype wire

### verif/format_string_number_printer_test.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// format_string_number_printer_test
// Self-checking testbench: drives format bytes, argument words and string
// arguments into the printer, predicts every output character, and compares
// each character transfer field by field against the predicted stream.
// ----------------------------------------------------------------------------
module format_string_number_printer_test;
    import fsnp_pkg::*;

    // One planned input transfer. When typed is set, the characters that the
    // item must produce are spelled out in text (right aligned, no zero
    // bytes), optionally followed by the message terminator when term is set.
    // Otherwise the expected characters come from the formatter model below.
    typedef struct packed {
        in_t         stim;
        logic        typed;
        logic [87:0] text;
        logic        term;
    } plan_t;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  item_valid;
    logic  item_stall;
    in_t   item;
    logic  char_valid;
    logic  char_stall;
    out_t  char_data;

    // Directed opening sequence. The typed rows are the ones whose output is
    // obvious: ignored items, extreme numbers and the terminator cases.
    plan_t directed_rows [0:26] = '{
        // Nothing is pending after reset, so words and null strings vanish.
        '{'{OP_WORD, 8'h00, 32'd5},          1'b1, 88'h0,          1'b0},
        '{'{OP_NULL, 8'hA5, 32'h0},          1'b1, 88'h0,          1'b0},
        // A plain byte with every bit set is copied through.
        '{'{OP_FMT,  8'hFF, 32'h0},          1'b0, 88'h0,          1'b0},
        // The most negative int must print in full.
        '{'{OP_FMT,  CHAR_PERCENT, 32'h0},   1'b1, 88'h0,          1'b0},
        '{'{OP_FMT,  CHAR_LOWER_I, 32'h0},   1'b1, 88'h0,          1'b0},
        '{'{OP_WORD, 8'h00, 32'h8000_0000},  1'b1, "-2147483648",  1'b0},
        // Largest unsigned value.
        '{'{OP_FMT,  CHAR_PERCENT, 32'h0},   1'b0, 88'h0,          1'b0},
        '{'{OP_FMT,  CHAR_LOWER_U, 32'h0},   1'b0, 88'h0,          1'b0},
        '{'{OP_WORD, 8'hFF, 32'hFFFF_FFFF},  1'b1, "4294967295",   1'b0},
        // Zero prints as a single digit.
        '{'{OP_FMT,  CHAR_PERCENT, 32'h0},   1'b0, 88'h0,          1'b0},
        '{'{OP_FMT,  CHAR_LOWER_X, 32'h0},   1'b0, 88'h0,          1'b0},
        '{'{OP_WORD, 8'h00, 32'h0},          1'b1, "0",            1'b0},
        // A character argument with a zero low byte does not end the message.
        '{'{OP_FMT,  CHAR_PERCENT, 32'h0},   1'b0, 88'h0,          1'b0},
        '{'{OP_FMT,  CHAR_LOWER_C, 32'h0},   1'b0, 88'h0,          1'b0},
        '{'{OP_WORD, 8'h00, 32'h0000_0100},  1'b0, 88'h0,          1'b0},
        // String argument: one byte, then the zero byte that closes it.
        '{'{OP_FMT,  CHAR_PERCENT, 32'h0},   1'b0, 88'h0,          1'b0},
        '{'{OP_FMT,  CHAR_LOWER_S, 32'h0},   1'b0, 88'h0,          1'b0},
        '{'{OP_STR,  8'h6B, 32'h0},          1'b0, 88'h0,          1'b0},
        '{'{OP_STR,  CHAR_NUL, 32'hFFFF_FFFF}, 1'b1, 88'h0,        1'b0},
        // Null string argument.
        '{'{OP_FMT,  CHAR_PERCENT, 32'h0},   1'b0, 88'h0,          1'b0},
        '{'{OP_FMT,  CHAR_LOWER_S, 32'h0},   1'b0, 88'h0,          1'b0},
        '{'{OP_NULL, 8'h00, 32'h0},          1'b1, "(null)",       1'b0},
        // A format byte abandons a pending argument and is copied as usual.
        '{'{OP_FMT,  CHAR_PERCENT, 32'h0},   1'b0, 88'h0,          1'b0},
        '{'{OP_FMT,  CHAR_LOWER_D, 32'h0},   1'b0, 88'h0,          1'b0},
        '{'{OP_FMT,  8'h5A, 32'h0},          1'b0, 88'h0,          1'b0},
        // A percent sign at the very end still terminates the message.
        '{'{OP_FMT,  CHAR_PERCENT, 32'h0},   1'b1, 88'h0,          1'b0},
        '{'{OP_FMT,  CHAR_NUL, 32'h0},       1'b1, 88'h0,          1'b1}
    };

    // Conversion characters the random part picks from.
    logic [7:0] spec_chars [0:7] = '{CHAR_LOWER_D, CHAR_LOWER_I, CHAR_LOWER_U,
                                     CHAR_LOWER_X, CHAR_UPPER_X, CHAR_LOWER_C,
                                     CHAR_LOWER_S, CHAR_PERCENT};

    plan_t item_plan [$];        // every input transfer, in order
    out_t  expected_chars [$];   // characters still owed by the printer
    int    items_taken = 0;      // input transfers completed so far
    int    chars_taken = 0;      // output transfers completed so far
    int    failures = 0;

    // Formatter model state.
    logic       spec_armed;      // a '%' was seen, conversion char comes next
    logic [2:0] arg_kind;        // which argument the printer is waiting for

    // Characters that the current input item produces.
    out_t line [0:10];
    int   line_len;

    format_string_number_printer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void emit(input logic [7:0] c, input logic ends);
        line[line_len] = '{c, 1'b0, ends};
        line_len++;
    endfunction

    // Works out the characters one input item produces and advances the
    // formatter state. The result lands in line[0 : line_len-1].
    function automatic void format_item(input in_t it);
        logic [31:0] mag;
        logic [31:0] base;
        logic [7:0]  digs [0:9];
        logic [3:0]  d;
        int          nd;
        string       null_text;
        line_len  = 0;
        base      = 32'd0;
        mag       = it.value;
        nd        = 0;
        null_text = "(null)";
        case (it.op)
            OP_FMT:
            begin
                // Any format byte drops an argument that never came.
                arg_kind = KIND_NONE;
                if (spec_armed)
                begin
                    spec_armed = 1'b0;
                    case (it.byte_in)
                        CHAR_NUL:                   emit(CHAR_NUL, 1'b1);
                        CHAR_LOWER_D, CHAR_LOWER_I: arg_kind = KIND_SDEC;
                        CHAR_LOWER_U:               arg_kind = KIND_UDEC;
                        CHAR_LOWER_X, CHAR_UPPER_X: arg_kind = KIND_HEX;
                        CHAR_LOWER_C:               arg_kind = KIND_CHAR;
                        CHAR_LOWER_S:               arg_kind = KIND_STR;
                        CHAR_PERCENT:               emit(CHAR_PERCENT, 1'b0);
                        default:                    ;
                    endcase
                end
                else if (it.byte_in == CHAR_NUL)
                    emit(CHAR_NUL, 1'b1);
                else if (it.byte_in == CHAR_PERCENT)
                    spec_armed = 1'b1;
                else
                    emit(it.byte_in, 1'b0);
            end
            OP_WORD:
            begin
                case (arg_kind)
                    KIND_SDEC:
                    begin
                        base = 32'd10;
                        if (it.value[31])
                        begin
                            emit(CHAR_MINUS, 1'b0);
                            mag = ~it.value + 32'd1;
                        end
                    end
                    KIND_UDEC: base = 32'd10;
                    KIND_HEX:  base = 32'd16;
                    KIND_CHAR: emit(it.value[7:0], 1'b0);
                    default:   ;
                endcase
                // A word is swallowed silently while a string is pending.
                if (arg_kind != KIND_STR)
                    arg_kind = KIND_NONE;
            end
            OP_STR:
            begin
                if (arg_kind == KIND_STR)
                begin
                    if (it.byte_in == CHAR_NUL)
                        arg_kind = KIND_NONE;
                    else
                        emit(it.byte_in, 1'b0);
                end
            end
            default:
            begin
                if (arg_kind == KIND_STR)
                begin
                    for (int i = 0; i < 6; i++)
                        emit(null_text[i], 1'b0);
                    arg_kind = KIND_NONE;
                end
            end
        endcase
        // Digits are collected least significant first, then sent out in
        // reverse. The do-while gives a lone '0' for a zero argument.
        if (base != 32'd0)
        begin
            do
            begin
                d = 4'(mag % base);
                digs[nd] = (d < 4'd10) ? CHAR_ZERO + d : CHAR_UPPER_A + (d - 4'd10);
                nd++;
                mag = mag / base;
            end
            while (mag != 32'd0);
            for (int i = nd - 1; i >= 0; i--)
                emit(digs[i], 1'b0);
        end
    endfunction

    // Argument words lean on the corner values of a 32-bit int.
    function automatic logic [31:0] arg_word();
        logic [31:0] w;
        case ($urandom_range(0, 7))
            0:       w = 32'h0;
            1:       w = 32'hFFFF_FFFF;
            2:       w = 32'h8000_0000;
            3:       w = 32'h7FFF_FFFF;
            4:       w = $urandom_range(0, 20);
            default: w = $urandom;
        endcase
        return w;
    endfunction

    function automatic void add_item(input logic [1:0] op, input logic [7:0] b,
                                     input logic [31:0] v);
        plan_t row;
        row = '0;
        row.stim = '{op, b, v};
        item_plan.push_back(row);
    endfunction

    // One random message: a few segments of plain text and conversions,
    // sprinkled with stray items and incomplete conversions, then the zero
    // byte that ends it.
    function automatic void add_message();
        int         segs;
        int         pick;
        int         slen;
        logic [7:0] b;
        logic [7:0] spec;
        segs = $urandom_range(1, 6);
        for (int s = 0; s < segs; s++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), arg_word());
            else if (pick < 35)
            begin
                do
                    b = 8'($urandom_range(1, 255));
                while (b == CHAR_PERCENT);
                add_item(OP_FMT, b, $urandom);
            end
            else
            begin
                add_item(OP_FMT, CHAR_PERCENT, $urandom);
                if ($urandom_range(0, 9) == 0)
                    spec = 8'($urandom_range(0, 255));
                else
                    spec = spec_chars[$urandom_range(0, 7)];
                add_item(OP_FMT, spec, $urandom);
                if (spec == CHAR_LOWER_S)
                begin
                    if ($urandom_range(0, 3) == 0)
                        add_item(OP_NULL, 8'($urandom_range(0, 255)), $urandom);
                    else
                    begin
                        slen = $urandom_range(0, 5);
                        for (int i = 0; i < slen; i++)
                            add_item(OP_STR, 8'($urandom_range(1, 255)), $urandom);
                        if ($urandom_range(0, 9) != 0)
                            add_item(OP_STR, CHAR_NUL, $urandom);
                    end
                end
                else if (spec != CHAR_PERCENT && $urandom_range(0, 9) != 0)
                    add_item(OP_WORD, 8'($urandom_range(0, 255)), arg_word());
            end
        end
        if ($urandom_range(0, 9) == 0)
            add_item(OP_FMT, CHAR_PERCENT, $urandom);
        add_item(OP_FMT, CHAR_NUL, $urandom);
    endfunction

    // Idle length for either side: mostly none or short, now and then long,
    // and occasionally a quiet stretch with no idling at all.
    function automatic int idle_gap(inout int quiet);
        int r;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void report(input string what, input out_t want, input out_t got);
        failures++;
        if (failures <= 10)
            $display("%0t: %s: expected %02h run_last %0b message_end %0b, got %02h run_last %0b message_end %0b",
                     $time, what, want.out_byte, want.run_last, want.message_end,
                     got.out_byte, got.run_last, got.message_end);
    endfunction

    // Scoreboard. Both channels are sampled at the rising edge, before the
    // printer or the drivers update anything in this time step. An input
    // transfer appends its predicted characters; an output transfer is
    // checked against the oldest character still owed.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                format_item(item);
                if (item_plan[items_taken].typed)
                begin
                    // The model still ran to keep its state in step, but the
                    // spelled-out characters take the place of its output.
                    line_len = 0;
                    for (int i = 10; i >= 0; i--)
                    begin
                        if (item_plan[items_taken].text[8*i +: 8] != CHAR_NUL)
                        begin
                            line[line_len] = '{item_plan[items_taken].text[8*i +: 8],
                                               1'b0, 1'b0};
                            line_len++;
                        end
                    end
                    if (item_plan[items_taken].term)
                        emit(CHAR_NUL, 1'b1);
                end
                if (line_len > 0)
                    line[line_len - 1].run_last = 1'b1;
                for (int i = 0; i < line_len; i++)
                    expected_chars.push_back(line[i]);
                items_taken++;
            end
            if (char_valid && !char_stall)
            begin
                if (expected_chars.size() == 0)
                    report("unexpected character transfer", '0, char_data);
                else if (char_data.out_byte    !== expected_chars[0].out_byte ||
                         char_data.run_last    !== expected_chars[0].run_last ||
                         char_data.message_end !== expected_chars[0].message_end)
                    report("character mismatch", expected_chars.pop_front(), char_data);
                else
                    void'(expected_chars.pop_front());
                chars_taken++;
            end
        end
    end

    // Sender: builds the whole plan, releases reset, then offers one item per
    // transfer with random gaps. The payload holds still while stalled.
    initial
    begin
        int quiet;
        int gap;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        spec_armed = 1'b0;
        arg_kind   = KIND_NONE;
        quiet      = 0;
        foreach (directed_rows[r])
            item_plan.push_back(directed_rows[r]);
        while (item_plan.size() < 380)
            add_message();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < item_plan.size(); k++)
        begin
            gap = idle_gap(quiet);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            item_valid <= 1'b1;
            item       <= item_plan[k].stim;
            @(posedge clk);
            while (item_stall)
                @(posedge clk);
        end
        item_valid <= 1'b0;

        // Drain: every item taken and every owed character delivered, then a
        // tail longer than one full-width decimal conversion to catch extras.
        while (items_taken < item_plan.size() || expected_chars.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        if (failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random stalls on the character side, plus one long hold-off
    // once the random part is under way, so the single output register fills
    // and the printer has to push back on its input while items keep coming.
    initial
    begin
        int quiet;
        int free_len;
        int hold_len;
        bit held;
        char_stall = 1'b0;
        quiet      = 0;
        held       = 1'b0;
        wait (rst_n);
        forever
        begin
            free_len = idle_gap(quiet);
            char_stall <= 1'b0;
            repeat (free_len + 1) @(posedge clk);
            if (!held && chars_taken >= 60)
            begin
                held     = 1'b1;
                hold_len = 400;
            end
            else
                hold_len = idle_gap(quiet);
            if (hold_len > 0)
            begin
                char_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
            end
        end
    end

    // Watchdog, sized well beyond the slowest legal run.
    initial
    begin
        #25_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire

### files.f
+incdir+src
src/fsnp_pkg.sv
src/fsnp_datapath.sv
src/fsnp_controller.sv
src/format_string_number_printer.sv
src/fsnp_checker.sv
verif/format_string_number_printer_test.sv
